### hw/rtl/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// shared types and constants for the ultrasonic ranger with obstacle stop
// ----------------------------------------------------------------------------
`default_nettype none

package urs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned PhCntW   = 20;
  localparam int unsigned DistW    = 16;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned TrigW    = 8;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] CFG_TRIG_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TRIG_HIGH   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_CM = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STOP_DIST   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CRUISE      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE       = 3'd5;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef struct packed {
    logic [TrigW-1:0]  trig_low_ticks;
    logic [TrigW-1:0]  trig_high_ticks;
    logic [DistW-1:0]  ticks_per_cm;
    logic [DistW-1:0]  stop_distance;
    logic [SpeedW-1:0] cruise_speed;
    logic [PhCntW-1:0] pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic              trigger_level;
    logic              distance_done;
    logic [DistW-1:0]  distance_units;
    logic [SpeedW-1:0] motor_speed;
    logic              motors_stopped;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/urs_in_if.sv
// ----------------------------------------------------------------------------
// urs_in_if
// tick channel carrying the sampled echo level
// ----------------------------------------------------------------------------
`default_nettype none

interface urs_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

### hw/rtl/urs_out_if.sv
// ----------------------------------------------------------------------------
// urs_out_if
// result channel: trigger, report strobe, distance and motor drive
// ----------------------------------------------------------------------------
`default_nettype none

interface urs_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic        distance_done;
  logic [15:0] distance_units;
  logic [7:0]  motor_speed;
  logic        motors_stopped;

  modport source (output valid, output trigger_level, output distance_done,
                  output distance_units, output motor_speed, output motors_stopped,
                  input ready);
  modport sink   (input valid, input trigger_level, input distance_done,
                  input distance_units, input motor_speed, input motors_stopped,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/urs_cfg_if.sv
// ----------------------------------------------------------------------------
// urs_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface urs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/urs_core.sv
// ----------------------------------------------------------------------------
// urs_core
// phase sequencer, echo width to distance counter and motor decision
// ----------------------------------------------------------------------------
`default_nettype none

module urs_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire urs_pkg::cfg_t cfg,
  input  wire logic         step,
  input  wire logic         echo,
  output urs_pkg::res_t     res
);
  import urs_pkg::*;

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_MEASURE   = 3'd3,
    PH_PAUSE     = 3'd4
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [PhCntW-1:0] phase_cnt_r, phase_cnt_nxt;
  logic [DistW-1:0]  sub_r, sub_nxt;
  logic [DistW-1:0]  dist_r, dist_nxt;
  logic [DistW-1:0]  last_r, last_nxt;
  logic [SpeedW-1:0] speed_r, speed_nxt;
  logic              stopped_r, stopped_nxt;

  logic [PhCntW:0]   cnt_inc;
  logic [PhCntW-1:0] low_len, high_len, timed_len;
  logic              timed_end;
  logic [DistW-1:0]  div_eff, sub_base, dist_base, tick_sub, tick_dist;
  logic [DistW:0]    sub_inc;
  logic              trig, done;

  // zero lengths act as one
  assign low_len  = (cfg.trig_low_ticks == '0) ? PhCntW'(1)
                                               : PhCntW'(cfg.trig_low_ticks);
  assign high_len = (cfg.trig_high_ticks == '0) ? PhCntW'(1)
                                                : PhCntW'(cfg.trig_high_ticks);
  assign div_eff  = (cfg.ticks_per_cm == '0) ? DistW'(1) : cfg.ticks_per_cm;

  always_comb begin
    case (phase_r)
      PH_TRIG_HIGH: timed_len = high_len;
      PH_PAUSE:     timed_len = cfg.pause_ticks;
      default:      timed_len = low_len;
    endcase
  end

  assign cnt_inc   = {1'b0, phase_cnt_r} + (PhCntW+1)'(1);
  assign timed_end = cnt_inc >= {1'b0, timed_len};

  // one high tick of the echo; a new measurement starts from zero
  assign sub_base  = (phase_r == PH_WAIT_RISE) ? '0 : sub_r;
  assign dist_base = (phase_r == PH_WAIT_RISE) ? '0 : dist_r;
  assign sub_inc   = {1'b0, sub_base} + (DistW+1)'(1);

  always_comb begin
    if (sub_inc >= {1'b0, div_eff}) begin
      tick_sub  = '0;
      tick_dist = (dist_base == DistMax) ? dist_base : dist_base + DistW'(1);
    end else begin
      tick_sub  = sub_inc[DistW-1:0];
      tick_dist = dist_base;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    sub_nxt       = sub_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    speed_nxt     = speed_r;
    stopped_nxt   = stopped_r;
    trig          = 1'b0;
    done          = 1'b0;
    unique case (phase_r)
      PH_TRIG_HIGH: begin
        trig = 1'b1;
        if (timed_end) begin
          phase_nxt     = PH_WAIT_RISE;
          phase_cnt_nxt = '0;
        end else begin
          phase_cnt_nxt = cnt_inc[PhCntW-1:0];
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          sub_nxt       = tick_sub;
          dist_nxt      = tick_dist;
          phase_nxt     = PH_MEASURE;
          phase_cnt_nxt = '0;
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          sub_nxt  = tick_sub;
          dist_nxt = tick_dist;
        end else begin
          done     = 1'b1;
          last_nxt = dist_r;
          if (dist_r < cfg.stop_distance) begin
            stopped_nxt = 1'b1;
            speed_nxt   = '0;
          end else begin
            stopped_nxt = 1'b0;
            speed_nxt   = cfg.cruise_speed;
          end
          phase_nxt     = (cfg.pause_ticks != '0) ? PH_PAUSE : PH_TRIG_LOW;
          phase_cnt_nxt = '0;
        end
      end
      PH_PAUSE: begin
        if (timed_end) begin
          phase_nxt     = PH_TRIG_LOW;
          phase_cnt_nxt = '0;
        end else begin
          phase_cnt_nxt = cnt_inc[PhCntW-1:0];
        end
      end
      default: begin
        if (timed_end) begin
          phase_nxt     = PH_TRIG_HIGH;
          phase_cnt_nxt = '0;
        end else begin
          phase_cnt_nxt = cnt_inc[PhCntW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRIG_LOW;
      phase_cnt_r <= '0;
      sub_r       <= '0;
      dist_r      <= '0;
      last_r      <= '0;
      speed_r     <= '0;
      stopped_r   <= 1'b1;
    end else if (step) begin
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      sub_r       <= sub_nxt;
      dist_r      <= dist_nxt;
      last_r      <= last_nxt;
      speed_r     <= speed_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  always_comb begin
    res.trigger_level  = trig;
    res.distance_done  = done;
    res.distance_units = last_nxt;
    res.motor_speed    = speed_nxt;
    res.motors_stopped = stopped_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/ultrasonic_ranger_obstacle_stop.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_obstacle_stop
// ultrasonic ranging controller that stops the motors near an obstacle
// ----------------------------------------------------------------------------
//
//   channel   dir   word
//   in_chan   in    one tick with the sampled echo level
//   out_chan  out   one word per tick: trigger, report strobe, distance, motors
//   cfg_chan  in    register index and write data, always ready
//
// one tick per clock while input ready is high: each word is handled in a single
// pass from the input port through the phase logic into the output register,
// or into the skid register while an earlier word waits in the output register.
// a two-entry output buffer (output register plus skid register) keeps input
// ready high while one finished word waits; ready drops only when both are full.
// synchronous active-low reset restores the register defaults and the trigger
// low phase with the motors stopped.
//
`default_nettype none

module ultrasonic_ranger_obstacle_stop (
  input  wire logic clk,
  input  wire logic rst_n,
  urs_in_if.sink    in_chan,
  urs_out_if.source out_chan,
  urs_cfg_if.sink   cfg_chan
);
  import urs_pkg::*;

  // configuration registers
  cfg_t cfg_r;

  // output register and skid register
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  res_t res;
  logic in_acc, out_take;

  // the config port never stalls
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_low_ticks  <= TrigW'(4);
      cfg_r.trig_high_ticks <= TrigW'(20);
      cfg_r.ticks_per_cm    <= DistW'(58);
      cfg_r.stop_distance   <= DistW'(15);
      cfg_r.cruise_speed    <= SpeedW'(150);
      cfg_r.pause_ticks     <= PhCntW'(600000);
    end else if (cfg_chan.valid) begin
      // writes beyond the last register are dropped
      unique case (cfg_chan.index)
        CFG_TRIG_LOW:     cfg_r.trig_low_ticks  <= cfg_chan.data[TrigW-1:0];
        CFG_TRIG_HIGH:    cfg_r.trig_high_ticks <= cfg_chan.data[TrigW-1:0];
        CFG_TICKS_PER_CM: cfg_r.ticks_per_cm    <= cfg_chan.data[DistW-1:0];
        CFG_STOP_DIST:    cfg_r.stop_distance   <= cfg_chan.data[DistW-1:0];
        CFG_CRUISE:       cfg_r.cruise_speed    <= cfg_chan.data[SpeedW-1:0];
        CFG_PAUSE:        cfg_r.pause_ticks     <= cfg_chan.data[PhCntW-1:0];
        default: ;
      endcase
    end
  end

  // input is taken whenever the skid slot is free
  assign in_chan.ready = !skid_valid_r;
  assign in_acc        = in_chan.valid && !skid_valid_r;
  assign out_take      = out_valid_r && out_chan.ready;

  // phase logic; state advances only on an accepted tick
  urs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (in_acc),
    .echo  (in_chan.echo_level),
    .res   (res)
  );

  // output buffering
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (out_take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.trigger_level  = out_r.trigger_level;
  assign out_chan.distance_done  = out_r.distance_done;
  assign out_chan.distance_units = out_r.distance_units;
  assign out_chan.motor_speed    = out_r.motor_speed;
  assign out_chan.motors_stopped = out_r.motors_stopped;

  // the skid slot fills only behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  // an accepted tick always leaves a valid output word in the next cycle
  a_acc_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted tick lost");

  // a report never coincides with the trigger pulse
  a_done_no_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.distance_done |-> !out_r.trigger_level)
    else $error("report during trigger pulse");

  // stopped motors run at zero duty
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.motors_stopped |-> out_r.motor_speed == '0)
    else $error("stopped with nonzero speed");

endmodule

`default_nettype wire
